@@ src/bacq_pkg.sv @@
package bacq_pkg;

    localparam int MAX_BLOCK = 40;
    localparam int IDX_W     = $clog2(MAX_BLOCK);
    localparam int PIX_W     = 8;
    localparam int BS_W      = 6;
    localparam int CL_W      = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_CH    = 3;

    // widest dividend: a full column sum plus the rounding half
    localparam int SUM_W = $clog2(MAX_BLOCK * 255 + MAX_BLOCK / 2 + 1);
    localparam int DSR_W = 9;
    localparam int CNT_W = $clog2(SUM_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_LEVELS = CFG_IDX_W'(1);

    localparam logic [BS_W-1:0]  BS_RESET      = BS_W'(5);
    localparam logic [CL_W-1:0]  CL_RESET      = CL_W'(4);
    localparam logic [CL_W-1:0]  CL_MAX        = CL_W'(256);
    localparam logic [SUM_W-1:0] STEP_DIVIDEND = SUM_W'(256);

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic             start;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CDIV,
        ST_TSTART,
        ST_TDIV,
        ST_SDIV,
        ST_PDIV,
        ST_EMIT
    } state_t;

endpackage

@@ src/bacq_if.sv @@
interface bacq_pixel_if;
    logic                valid;
    logic                ready;
    bacq_pkg::pix_t      pixel_blue;
    bacq_pkg::pix_t      pixel_green;
    bacq_pkg::pix_t      pixel_red;

    modport source (output valid, output pixel_blue, output pixel_green, output pixel_red,
                    input ready);
    modport sink   (input valid, input pixel_blue, input pixel_green, input pixel_red,
                    output ready);
endinterface

interface bacq_tile_if;
    logic                valid;
    logic                ready;
    bacq_pkg::pix_t      tile_blue;
    bacq_pkg::pix_t      tile_green;
    bacq_pkg::pix_t      tile_red;

    modport source (output valid, output tile_blue, output tile_green, output tile_red,
                    input ready);
    modport sink   (input valid, input tile_blue, input tile_green, input tile_red,
                    output ready);
endinterface

@@ src/bacq_div.sv @@
module bacq_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bacq_pkg::div_req_t             req,
    input  bacq_pkg::sum_t                 dividend,
    output logic                           done,
    output bacq_pkg::sum_t                 quotient,
    output logic [bacq_pkg::DSR_W-1:0]     remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [bacq_pkg::CNT_W-1:0]    cnt_reg;
    bacq_pkg::sum_t                dvd_reg;
    logic [bacq_pkg::DSR_W-1:0]    rem_reg;
    logic [bacq_pkg::DSR_W-1:0]    dsr_reg;

    logic [bacq_pkg::DSR_W:0]      trial;
    logic                          fits;
    logic [bacq_pkg::DSR_W-1:0]    rem_next;
    logic [bacq_pkg::DSR_W:0]      diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[bacq_pkg::SUM_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_next = fits ? diff[bacq_pkg::DSR_W-1:0] : trial[bacq_pkg::DSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= bacq_pkg::CNT_W'(bacq_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - bacq_pkg::CNT_W'(1);
                if (cnt_reg == bacq_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[bacq_pkg::SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

@@ src/block_average_color_quantizer_top.sv @@
// tile average color quantizer
// pix channel: one bgr pixel per item, tiles of block_size x block_size pixels sent
// row by row, left to right; tile channel: one quantized color item per completed tile.
// cfg port: cfg_we writes cfg_data into register cfg_index (0 block_size, 1 color_levels)
// at the clock edge; any write drops the tile in progress. write only while idle.
// flow: a pixel that does not end a column is accepted, then a read-modify-write of the
// column sum memory follows. a pixel on the last row instead runs the three channel
// lanes of the bit-serial divider, one quotient bit per cycle over 14 bits. the last
// pixel of a tile adds three more divider passes (tile mean, posterize step, posterize
// remainder) before the color item is loaded into the output register.
// the output register lets the next tile start while a color waits; if the receiver
// still holds an earlier color when a new one is done, the block waits with pix.ready low.
// reset: block_size 5, color_levels 4, positions and running totals cleared, no item held.
module block_average_color_quantizer_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bacq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bacq_pkg::CFG_W-1:0]           cfg_data,
    bacq_pixel_if.sink                           pix,
    bacq_tile_if.source                          tile
);

    localparam int NCH = bacq_pkg::NUM_CH;
    localparam int SW  = bacq_pkg::SUM_W;

    // configuration
    logic [bacq_pkg::BS_W-1:0]   bs_reg;
    logic [bacq_pkg::CL_W-1:0]   cl_reg;
    logic [bacq_pkg::BS_W-1:0]   n_eff;
    logic [bacq_pkg::CL_W-1:0]   l_eff;
    bacq_pkg::sum_t              n_half;

    // position within the tile and running totals of column means
    logic [bacq_pkg::IDX_W-1:0]  row_reg;
    logic [bacq_pkg::IDX_W-1:0]  col_reg;
    bacq_pkg::sum_t              tot_reg [NCH];
    logic                        row_last;
    logic                        col_last;

    // fsm
    bacq_pkg::state_t            state_reg;
    bacq_pkg::state_t            state_next;
    logic                        div_start;
    logic                        mem_we;
    logic                        load_out;
    logic                        pix_ready;

    // datapath
    bacq_pkg::pix_t              pix_reg [NCH];
    logic [NCH*SW-1:0]           rd_reg;
    logic [NCH*SW-1:0]           col_mem [bacq_pkg::MAX_BLOCK];
    bacq_pkg::sum_t              acc_sum [NCH];
    logic [NCH*SW-1:0]           wr_data;
    bacq_pkg::pix_t              mean_reg [NCH];
    logic [bacq_pkg::DSR_W-1:0]  step_reg;
    bacq_pkg::pix_t              res [NCH];
    bacq_pkg::pix_t              res_reg [NCH];
    bacq_pkg::pix_t              out_reg [NCH];
    logic                        out_valid_reg;

    // divider lanes, one per channel
    bacq_pkg::div_req_t          div_req;
    bacq_pkg::sum_t              div_dvd [NCH];
    logic                        div_done [NCH];
    bacq_pkg::sum_t              div_q [NCH];
    logic [bacq_pkg::DSR_W-1:0]  div_rem [NCH];

    // effective sizes: zero acts as one, too large clamps
    always_comb
    begin
        if (bs_reg == '0)
            n_eff = bacq_pkg::BS_W'(1);
        else if ({1'b0, bs_reg} > (bacq_pkg::BS_W + 1)'(bacq_pkg::MAX_BLOCK))
            n_eff = bacq_pkg::BS_W'(bacq_pkg::MAX_BLOCK);
        else
            n_eff = bs_reg;

        if (cl_reg == '0)
            l_eff = bacq_pkg::CL_W'(1);
        else if (cl_reg > bacq_pkg::CL_MAX)
            l_eff = bacq_pkg::CL_MAX;
        else
            l_eff = cl_reg;

        n_half = SW'(n_eff >> 1);
    end

    assign row_last = (bacq_pkg::BS_W'(row_reg) == n_eff - bacq_pkg::BS_W'(1));
    assign col_last = (bacq_pkg::BS_W'(col_reg) == n_eff - bacq_pkg::BS_W'(1));

    // column accumulate: the first row of a tile starts the column fresh,
    // so stale memory contents are never seen
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            acc_sum[ch] = ((row_reg == '0) ? '0 : rd_reg[ch*SW +: SW])
                          + SW'(pix_reg[ch]);
            wr_data[ch*SW +: SW] = acc_sum[ch];
        end
    end

    // posterize: mean / step * step is mean minus its remainder; half a step is added and the sum saturates at 255
    always_comb
    begin
        logic [bacq_pkg::PIX_W+1:0] post;
        for (int ch = 0; ch < NCH; ch++)
        begin
            post = {2'b00, mean_reg[ch]} - {1'b0, div_rem[ch]}
                   + {2'b00, step_reg[bacq_pkg::DSR_W-1:1]};
            res[ch] = (post > (bacq_pkg::PIX_W + 2)'(255)) ? '1 : post[bacq_pkg::PIX_W-1:0];
        end
    end

    // divider operand select by phase
    always_comb
    begin
        div_req.start   = div_start;
        div_req.divisor = '0;
        for (int ch = 0; ch < NCH; ch++)
            div_dvd[ch] = '0;
        case (state_reg)
            bacq_pkg::ST_ACC:
            begin
                div_req.divisor = bacq_pkg::DSR_W'(n_eff);
                for (int ch = 0; ch < NCH; ch++)
                    div_dvd[ch] = acc_sum[ch] + n_half;
            end
            bacq_pkg::ST_TSTART:
            begin
                div_req.divisor = bacq_pkg::DSR_W'(n_eff);
                for (int ch = 0; ch < NCH; ch++)
                    div_dvd[ch] = tot_reg[ch] + n_half;
            end
            bacq_pkg::ST_TDIV:
            begin
                // step = 256 / levels, taken from lane 0
                div_req.divisor = l_eff;
                for (int ch = 0; ch < NCH; ch++)
                    div_dvd[ch] = bacq_pkg::STEP_DIVIDEND;
            end
            bacq_pkg::ST_SDIV:
            begin
                div_req.divisor = div_q[0][bacq_pkg::DSR_W-1:0];
                for (int ch = 0; ch < NCH; ch++)
                    div_dvd[ch] = SW'(mean_reg[ch]);
            end
            default:
            begin
                div_req.divisor = '0;
            end
        endcase
    end

    // next state and control
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        load_out   = 1'b0;
        pix_ready  = 1'b0;
        case (state_reg)
            bacq_pkg::ST_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix.valid)
                    state_next = bacq_pkg::ST_ACC;
            end
            bacq_pkg::ST_ACC:
            begin
                if (row_last)
                begin
                    div_start  = 1'b1;
                    state_next = bacq_pkg::ST_CDIV;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = bacq_pkg::ST_IDLE;
                end
            end
            bacq_pkg::ST_CDIV:
            begin
                if (div_done[0])
                    state_next = col_last ? bacq_pkg::ST_TSTART : bacq_pkg::ST_IDLE;
            end
            bacq_pkg::ST_TSTART:
            begin
                div_start  = 1'b1;
                state_next = bacq_pkg::ST_TDIV;
            end
            bacq_pkg::ST_TDIV:
            begin
                if (div_done[0])
                begin
                    div_start  = 1'b1;
                    state_next = bacq_pkg::ST_SDIV;
                end
            end
            bacq_pkg::ST_SDIV:
            begin
                if (div_done[0])
                begin
                    div_start  = 1'b1;
                    state_next = bacq_pkg::ST_PDIV;
                end
            end
            bacq_pkg::ST_PDIV:
            begin
                if (div_done[0])
                    state_next = bacq_pkg::ST_EMIT;
            end
            bacq_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || tile.ready)
                begin
                    load_out   = 1'b1;
                    state_next = bacq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bacq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bacq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // config, positions, running totals, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg        <= bacq_pkg::BS_RESET;
            cl_reg        <= bacq_pkg::CL_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < NCH; ch++)
                tot_reg[ch] <= '0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (tile.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    bacq_pkg::REG_BLOCK_SIZE:   bs_reg <= cfg_data[bacq_pkg::BS_W-1:0];
                    bacq_pkg::REG_COLOR_LEVELS: cl_reg <= cfg_data[bacq_pkg::CL_W-1:0];
                    default:                    bs_reg <= bs_reg;
                endcase
                row_reg <= '0;
                col_reg <= '0;
                for (int ch = 0; ch < NCH; ch++)
                    tot_reg[ch] <= '0;
            end
            else
            begin
                // step to the next pixel position once the pixel is done
                if ((state_reg == bacq_pkg::ST_ACC && !row_last) ||
                    (state_reg == bacq_pkg::ST_CDIV && div_done[0]))
                begin
                    if (col_last)
                    begin
                        col_reg <= '0;
                        row_reg <= row_last ? '0 : row_reg + bacq_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + bacq_pkg::IDX_W'(1);
                    end
                end

                if (state_reg == bacq_pkg::ST_CDIV && div_done[0])
                begin
                    for (int ch = 0; ch < NCH; ch++)
                        tot_reg[ch] <= tot_reg[ch] + SW'(div_q[ch][bacq_pkg::PIX_W-1:0]);
                end
                else if (state_reg == bacq_pkg::ST_TSTART)
                begin
                    // dividend already taken by the divider this cycle
                    for (int ch = 0; ch < NCH; ch++)
                        tot_reg[ch] <= '0;
                end
            end
        end
    end

    // column sum memory, registered read at the current column
    always_ff @(posedge clk)
    begin
        rd_reg <= col_mem[col_reg];
        if (mem_we)
            col_mem[col_reg] <= wr_data;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pix.valid && pix_ready)
        begin
            pix_reg[0] <= pix.pixel_blue;
            pix_reg[1] <= pix.pixel_green;
            pix_reg[2] <= pix.pixel_red;
        end
        if (state_reg == bacq_pkg::ST_TDIV && div_done[0])
        begin
            for (int ch = 0; ch < NCH; ch++)
                mean_reg[ch] <= div_q[ch][bacq_pkg::PIX_W-1:0];
        end
        if (state_reg == bacq_pkg::ST_SDIV && div_done[0])
            step_reg <= div_q[0][bacq_pkg::DSR_W-1:0];
        if (state_reg == bacq_pkg::ST_PDIV && div_done[0])
        begin
            for (int ch = 0; ch < NCH; ch++)
                res_reg[ch] <= res[ch];
        end
        if (load_out)
        begin
            for (int ch = 0; ch < NCH; ch++)
                out_reg[ch] <= res_reg[ch];
        end
    end

    for (genvar g = 0; g < NCH; g++)
    begin : g_lane
        bacq_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .req       (div_req),
            .dividend  (div_dvd[g]),
            .done      (div_done[g]),
            .quotient  (div_q[g]),
            .remainder (div_rem[g])
        );
    end

    assign pix.ready       = pix_ready;
    assign tile.valid      = out_valid_reg;
    assign tile.tile_blue  = out_reg[0];
    assign tile.tile_green = out_reg[1];
    assign tile.tile_red   = out_reg[2];

endmodule

@@ src/bacq_checker.sv @@
module bacq_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pix_valid,
    input  logic                    pix_ready,
    input  logic                    tile_valid,
    input  logic                    tile_ready,
    input  logic [3*bacq_pkg::PIX_W-1:0] tile_data
);

    // a held color stays until taken
    a_tile_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_valid && !tile_ready) |=> tile_valid)
        else $error("tile item dropped while stalled");

    a_tile_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (tile_valid && !tile_ready) |=> $stable(tile_data))
        else $error("tile item changed while stalled");

    // a new color is only loaded while no pixel can be taken
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!tile_valid || tile_ready) ##1 tile_valid |-> !$past(pix_ready))
        else $error("color loaded while pixel input open");

    // pix_ready drops after each accepted pixel while its column is updated
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> !pix_ready)
        else $error("pixel taken on back-to-back cycles");

endmodule

bind block_average_color_quantizer_top bacq_checker u_bacq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix.valid),
    .pix_ready  (pix.ready),
    .tile_valid (tile.valid),
    .tile_ready (tile.ready),
    .tile_data  ({tile.tile_red, tile.tile_green, tile.tile_blue})
);

@@ dv/block_average_color_quantizer_top_tb.sv @@
`timescale 1ns / 1ps

module block_average_color_quantizer_top_tb;

    // number of random pixel items before the large-tile tail
    localparam int unsigned RANDOM_ITEMS  = 1200;
    // quiet time before a register write: covers a last-row divider pass of
    // an abandoned tile and the tile-mean divider passes
    localparam int unsigned SETTLE_CYCLES = 100;

    typedef struct packed {
        bacq_pkg::pix_t blue;
        bacq_pkg::pix_t green;
        bacq_pkg::pix_t red;
    } bgr_t;

    // pixel content styles for one tile
    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_NEAR
    } fill_t;

    // tracks the tile in progress and the colors still owed by the block
    class tile_color_scoreboard;
        logic [bacq_pkg::BS_W-1:0] side_reg;
        logic [bacq_pkg::CL_W-1:0] levels_reg;
        int unsigned     column_sum [bacq_pkg::MAX_BLOCK][3];
        int unsigned     mean_total [3];
        int unsigned     row_pos;
        int unsigned     col_pos;
        bgr_t            expected_colors [$];
        int unsigned     mismatches;

        function new();
            side_reg   = bacq_pkg::BS_RESET;
            levels_reg = bacq_pkg::CL_RESET;
            mismatches = 0;
            clear_tile();
        endfunction

        function void clear_tile();
            foreach (column_sum[i, ch])
                column_sum[i][ch] = 0;
            foreach (mean_total[ch])
                mean_total[ch] = 0;
            row_pos = 0;
            col_pos = 0;
        endfunction

        // side length in effect: zero acts as one, clamped to MAX_BLOCK
        function int unsigned tile_side();
            int unsigned s;
            s = side_reg;
            if (s == 0)
                s = 1;
            if (s > bacq_pkg::MAX_BLOCK)
                s = bacq_pkg::MAX_BLOCK;
            return s;
        endfunction

        function void write_reg(logic [bacq_pkg::CFG_IDX_W-1:0] idx,
                                logic [bacq_pkg::CFG_W-1:0] value);
            if (idx == bacq_pkg::REG_BLOCK_SIZE)
                side_reg = value[bacq_pkg::BS_W-1:0];
            else if (idx == bacq_pkg::REG_COLOR_LEVELS)
                levels_reg = value[bacq_pkg::CL_W-1:0];
            clear_tile();
        endfunction

        // accumulate one accepted pixel, queue a color when the tile ends
        function void add_pixel(bacq_pkg::pix_t blue, bacq_pkg::pix_t green,
                                bacq_pkg::pix_t red);
            int unsigned px [3];
            int unsigned n;
            int unsigned lv;
            int unsigned step;
            int unsigned q;
            bgr_t        color;
            px[0] = blue;
            px[1] = green;
            px[2] = red;
            n = tile_side();
            for (int ch = 0; ch < 3; ch++)
                column_sum[col_pos][ch] += px[ch];
            if (row_pos == n - 1)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    mean_total[ch] += (column_sum[col_pos][ch] + n / 2) / n;
                    column_sum[col_pos][ch] = 0;
                end
            end
            if (col_pos + 1 < n)
            begin
                col_pos++;
                return;
            end
            col_pos = 0;
            if (row_pos + 1 < n)
            begin
                row_pos++;
                return;
            end
            lv = levels_reg;
            if (lv == 0)
                lv = 1;
            if (lv > 256)
                lv = 256;
            step = 256 / lv;
            for (int ch = 0; ch < 3; ch++)
            begin
                q = ((mean_total[ch] + n / 2) / n) / step * step + step / 2;
                if (q > 255)
                    q = 255;
                px[ch] = q;
            end
            color.blue  = bacq_pkg::pix_t'(px[0]);
            color.green = bacq_pkg::pix_t'(px[1]);
            color.red   = bacq_pkg::pix_t'(px[2]);
            expected_colors.push_back(color);
            clear_tile();
        endfunction

        function void check_tile(bacq_pkg::pix_t blue, bacq_pkg::pix_t green,
                                 bacq_pkg::pix_t red);
            bgr_t want;
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected tile color b=%0d g=%0d r=%0d", blue, green, red);
                return;
            end
            want = expected_colors.pop_front();
            if (want.blue !== blue || want.green !== green || want.red !== red)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"tile color mismatch: expected b=%0d g=%0d r=%0d, ",
                              "got b=%0d g=%0d r=%0d"},
                             want.blue, want.green, want.red, blue, green, red);
            end
        endfunction

        function int unsigned pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bacq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bacq_pkg::CFG_W-1:0]     cfg_data;

    bacq_pixel_if pix_ch ();
    bacq_tile_if  tile_ch ();

    tile_color_scoreboard sb;

    // idle chances in percent per cycle for the pixel sender and color receiver
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned pixels_sent;

    block_average_color_quantizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .tile      (tile_ch)
    );

    always #2 clk = ~clk;

    function automatic void set_idle(int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endfunction

    // one pixel item: optional idle cycles first, then hold valid until taken
    task automatic send_pixel(bacq_pkg::pix_t blue, bacq_pkg::pix_t green,
                              bacq_pkg::pix_t red);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_blue  <= blue;
        pix_ch.pixel_green <= green;
        pix_ch.pixel_red   <= red;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        sb.add_pixel(blue, green, red);
        pixels_sent++;
    endtask

    // drop valid after the last item of a burst
    task automatic end_burst();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
    endtask

    task automatic wait_colors_done();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // block must be idle before a register write
    task automatic settle_for_config();
        wait_colors_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [bacq_pkg::CFG_IDX_W-1:0] idx,
                             logic [bacq_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    function automatic bacq_pkg::pix_t pick_channel(fill_t fill, bacq_pkg::pix_t base);
        int unsigned v;
        case (fill)
            FILL_RANDOM:  return bacq_pkg::pix_t'($urandom);
            FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:
            begin
                // small spread around a base value stresses the half-up rounding
                v = base + $urandom_range(0, 3);
                if (v > 255)
                    v = 255;
                return bacq_pkg::pix_t'(v);
            end
        endcase
    endfunction

    // send count pixels of one tile; pause_at marks an item before which the
    // sender stops and waits until every owed color has come out
    task automatic send_tile_pixels(int unsigned count, fill_t fill, int pause_at);
        bacq_pkg::pix_t base_b;
        bacq_pkg::pix_t base_g;
        bacq_pkg::pix_t base_r;
        base_b = bacq_pkg::pix_t'($urandom);
        base_g = bacq_pkg::pix_t'($urandom);
        base_r = bacq_pkg::pix_t'($urandom);
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
            begin
                end_burst();
                wait_colors_done();
            end
            send_pixel(pick_channel(fill, base_b), pick_channel(fill, base_g),
                       pick_channel(fill, base_r));
        end
    endtask

    // color receiver: ready changes on the falling edge
    always @(negedge clk)
        tile_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // result check at the rising edge
    always @(posedge clk)
        if (rst_n && tile_ch.valid && tile_ch.ready)
            sb.check_tile(tile_ch.tile_blue, tile_ch.tile_green, tile_ch.tile_red);

    // hard stop in case the block hangs
    initial
    begin
        #10000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned                random_base;
        int unsigned                n;
        int unsigned                tiles;
        int unsigned                count;
        int unsigned                mode;
        int unsigned                pick;
        int                         pause_at;
        bit                         force_write;
        logic [bacq_pkg::BS_W-1:0]  side_val;
        logic [bacq_pkg::CL_W-1:0]  levels_val;
        fill_t                      fill;

        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_blue  = '0;
        pix_ch.pixel_green = '0;
        pix_ch.pixel_red   = '0;
        pixels_sent        = 0;
        sb                 = new();
        set_idle(33, 49);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----

        // reset settings: 5x5 tile, 4 levels; blue flips 0/255, green ramps,
        // red counts down from full scale
        for (int i = 0; i < 25; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, bacq_pkg::pix_t'(i * 10),
                       bacq_pkg::pix_t'(255 - i));
        end_burst();

        // side zero acts as one, levels zero acts as one: every pixel is a tile
        // and every color is mid-scale
        settle_for_config();
        cfg_write(bacq_pkg::REG_BLOCK_SIZE, '0);
        cfg_write(bacq_pkg::REG_COLOR_LEVELS, '0);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        end_burst();

        // levels above 256 act as 256: color passes straight through
        settle_for_config();
        cfg_write(bacq_pkg::REG_COLOR_LEVELS, 9'h1FF);
        send_pixel(8'hFF, 8'h00, 8'h5A);
        end_burst();

        // three levels: step 85, a top value posterizes past 255 and saturates
        settle_for_config();
        cfg_write(bacq_pkg::REG_COLOR_LEVELS, 9'd3);
        send_pixel(8'hFF, 8'hFE, 8'h01);
        end_burst();

        // side 3 with upper data bits set (ignored); tile left unfinished and
        // dropped by the next register write
        settle_for_config();
        cfg_write(bacq_pkg::REG_BLOCK_SIZE, 9'h1C3);
        for (int i = 0; i < 4; i++)
            send_pixel(8'hFF, 8'h80, 8'h01);
        end_burst();
        force_write = 1'b1;

        // ---- random part ----
        random_base = pixels_sent;
        while (pixels_sent - random_base < RANDOM_ITEMS)
        begin
            // idle profile by progress: sender-light, then receiver-light, then none
            mode = (pixels_sent - random_base) * 3 / RANDOM_ITEMS;
            case (mode)
                0:       set_idle(33, 49);
                1:       set_idle(49, 33);
                default: set_idle(0, 0);
            endcase

            if (force_write || $urandom_range(0, 99) < 80)
            begin
                settle_for_config();
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    side_val = '0;
                else if (pick < 75)
                    side_val = bacq_pkg::BS_W'($urandom_range(1, 6));
                else if (pick < 95)
                    side_val = bacq_pkg::BS_W'($urandom_range(7, 12));
                else
                    side_val = bacq_pkg::BS_W'($urandom_range(13, 16));
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    levels_val = '0;
                else if (pick < 30)
                    levels_val = bacq_pkg::CL_W'(1 << $urandom_range(0, 8));
                else if (pick < 45)
                    levels_val = bacq_pkg::CL_W'($urandom_range(257, 511));
                else if (pick < 75)
                    levels_val = bacq_pkg::CL_W'($urandom_range(2, 16));
                else
                    levels_val = bacq_pkg::CL_W'($urandom_range(0, 511));
                // one or both registers, either order
                case ($urandom_range(0, 3))
                    0: cfg_write(bacq_pkg::REG_BLOCK_SIZE,
                                 {3'($urandom_range(0, 7)), side_val});
                    1: cfg_write(bacq_pkg::REG_COLOR_LEVELS, levels_val);
                    2:
                    begin
                        cfg_write(bacq_pkg::REG_BLOCK_SIZE,
                                  {3'($urandom_range(0, 7)), side_val});
                        cfg_write(bacq_pkg::REG_COLOR_LEVELS, levels_val);
                    end
                    default:
                    begin
                        cfg_write(bacq_pkg::REG_COLOR_LEVELS, levels_val);
                        cfg_write(bacq_pkg::REG_BLOCK_SIZE,
                                  {3'($urandom_range(0, 7)), side_val});
                    end
                endcase
                force_write = 1'b0;
            end

            n = sb.tile_side();
            tiles = (n > 8) ? 1 : $urandom_range(1, 4);
            for (int t = 0; t < tiles; t++)
            begin
                pick = $urandom_range(0, 99);
                fill = (pick < 60) ? FILL_RANDOM : (pick < 80) ? FILL_EXTREME : FILL_NEAR;
                count = n * n;
                // occasionally cut the last tile short; it gets dropped later
                if (t == tiles - 1 && count > 1 && $urandom_range(0, 99) < 12)
                begin
                    count = $urandom_range(1, n * n - 1);
                    force_write = 1'b1;
                end
                pause_at = ($urandom_range(0, 99) < 8) ?
                           int'($urandom_range(0, count - 1)) : -1;
                send_tile_pixels(count, fill, pause_at);
            end
            end_burst();
        end

        // largest tiles: side 40 abandoned after two rows, then side 63
        // (clamped to 40) abandoned after one row and one more pixel
        set_idle(0, 0);
        settle_for_config();
        cfg_write(bacq_pkg::REG_BLOCK_SIZE, 9'd40);
        cfg_write(bacq_pkg::REG_COLOR_LEVELS, bacq_pkg::CL_W'($urandom_range(0, 511)));
        send_tile_pixels(2 * bacq_pkg::MAX_BLOCK, FILL_RANDOM, -1);
        end_burst();
        settle_for_config();
        cfg_write(bacq_pkg::REG_BLOCK_SIZE, {3'($urandom_range(0, 7)), 6'd63});
        send_tile_pixels(bacq_pkg::MAX_BLOCK + 1, FILL_RANDOM, -1);
        end_burst();

        // drain and let the block go quiet
        wait_colors_done();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
